@@ hw/rtl/qtr_pkg.sv @@
package qtr_pkg;

  localparam int unsigned PIXEL_COUNT = 4096;
  localparam int unsigned PASSES      = 6;

  localparam int unsigned ADDR_W = $clog2(PIXEL_COUNT);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int unsigned TGT_W  = 17;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned HGT_W  = 8;
  localparam int unsigned MID_W  = HGT_W + 1;
  localparam int unsigned CFG_W  = TGT_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESCALE = 1'd1;

  localparam logic [TGT_W-1:0] TARGET_RESET = 17'd32768;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_RD_WAIT,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] pixel_index;
    logic [HGT_W-1:0]  height_in;
  } req_t;

  typedef struct packed {
    logic [HGT_W-1:0] threshold;
    logic [HGT_W-1:0] peak_height;
    logic [CNT_W-1:0] below_count;
    logic [HGT_W-1:0] height_out;
  } rsp_t;

endpackage

@@ hw/rtl/quantile_threshold_remap.sv @@
// Height map store with quantile threshold search and remapped read-back.
// A write request stores one 8-bit pixel and is taken with no
// response. A compute request walks the whole store PASSES times (six) through
// the single memory read port, one pixel per cycle, refining a bisection
// candidate per pass, each pass followed by a drain and an evaluate state;
// a compute holds the block until its response (threshold, peak height,
// final below count) is registered. A read request returns the pixel
// remapped against the last computed threshold; a rescaled pixel then
// passes through a division state, since the 255*(h-t)/(peak-t) quotient
// comes from one shared compare-subtract unit producing one quotient bit
// per cycle. One request is in flight at a time; a new one is taken once
// the block is idle and its output register is free or being drained.
// Configuration writes are taken at any edge but must only be issued while
// the block is idle. The store has no reset; reading a pixel never written
// gives an undefined value.
module quantile_threshold_remap
  import qtr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  // response channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_rsp_q, out_rsp_d;
  logic                vld_q, vld_d;          // read data in rd_q is a scan pixel
  logic [HGT_W-1:0]    found_t_q, found_t_d;
  logic [HGT_W-1:0]    found_p_q, found_p_d;
  logic [TGT_W-1:0]    target_q;
  logic                rescale_q;

  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [HGT_W-1:0]    peak_q, peak_d;
  logic [MID_W-1:0]    lo_q, lo_d;
  logic [MID_W-1:0]    hi_q, hi_d;
  logic [PASS_W-1:0]   pass_q, pass_d;
  logic [HGT_W-1:0]    rem_q, rem_d;
  logic [HGT_W-1:0]    quo_q, quo_d;
  logic [HGT_W-1:0]    dvs_q, dvs_d;
  logic [2:0]          step_q, step_d;

  logic [HGT_W-1:0]    mem [PIXEL_COUNT];
  logic [HGT_W-1:0]    rd_q;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_take;
  op_e  in_op;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_take    = out_valid_q && out_ready_i;
  assign in_op       = op_e'(in_req_i.operation);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------------------------------------------------------------------
  // Height store: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;

  assign mem_we = in_fire && (in_op == OP_WRITE);
  assign mem_re = (in_fire && (in_op == OP_READ)) || (state_q == ST_SCAN);
  assign mem_ra = (state_q == ST_SCAN) ? addr_q : in_req_i.pixel_index;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_req_i.pixel_index] <= in_req_i.height_in;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // ---------------------------------------------------------------------------
  // Bisection candidate: mid = (lo + hi) / 2, threshold = floor(255 * mid / 256)
  // ---------------------------------------------------------------------------
  logic [MID_W:0]         mid_sum;
  logic [MID_W-1:0]       mid;
  logic [MID_W+HGT_W-1:0] mid_x255;
  logic [HGT_W-1:0]       t_cand;
  logic                   go_low;     // count still short of the target: raise low

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[MID_W:1];
  assign mid_x255 = {mid, {HGT_W{1'b0}}} - {{HGT_W{1'b0}}, mid};
  assign t_cand   = mid_x255[2*HGT_W-1:HGT_W];

  // target * PIXEL_COUNT > count * 65536, both sides as shifts
  assign go_low = {target_q, {ADDR_W{1'b0}}} > {cnt_q, {FRAC_W{1'b0}}};

  // ---------------------------------------------------------------------------
  // Remap setup for a read: 255 * (h - t) over (peak - t)
  // ---------------------------------------------------------------------------
  logic [HGT_W-1:0]   h_diff;
  logic [2*HGT_W-1:0] num;
  logic [HGT_W-1:0]   dvs_init;
  logic               num_ovf;

  assign h_diff   = rd_q - found_t_q;
  assign num      = {h_diff, {HGT_W{1'b0}}} - {{HGT_W{1'b0}}, h_diff};
  assign dvs_init = found_p_q - found_t_q;
  assign num_ovf  = num[2*HGT_W-1:HGT_W] >= dvs_init;

  // Shared compare-subtract: one restoring division step per cycle
  logic [HGT_W:0]   r_shift;
  logic [HGT_W:0]   r_sub;
  logic             r_ge;
  logic [HGT_W-1:0] quo_next;

  assign r_shift  = {rem_q, quo_q[HGT_W-1]};
  assign r_sub    = r_shift - {1'b0, dvs_q};
  assign r_ge     = r_shift >= {1'b0, dvs_q};
  assign quo_next = {quo_q[HGT_W-2:0], r_ge};

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_COMPUTE: state_d = ST_SCAN;
            OP_READ:    state_d = ST_RD_WAIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (addr_q == ADDR_W'(PIXEL_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EVAL;
      ST_EVAL: begin
        if (pass_q == PASS_W'(PASSES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_RD_WAIT: begin
        if (rd_q < found_t_q || !rescale_q || found_p_q <= found_t_q || num_ovf) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and response
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    vld_d       = 1'b0;
    found_t_d   = found_t_q;
    found_p_d   = found_p_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    peak_d      = peak_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pass_d      = pass_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    step_d      = step_q;

    // fold in the pixel fetched last cycle
    if (vld_q) begin
      if (rd_q < t_cand) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (rd_q > peak_q) begin
        peak_d = rd_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_op == OP_COMPUTE) begin
          addr_d = '0;
          cnt_d  = '0;
          peak_d = '0;
          lo_d   = '0;
          hi_d   = MID_W'(1 << HGT_W);
          pass_d = '0;
        end
      end
      ST_SCAN: begin
        vld_d  = 1'b1;
        addr_d = addr_q + ADDR_W'(1);
      end
      ST_EVAL: begin
        if (go_low) begin
          lo_d = mid;
        end else begin
          hi_d = mid;
        end
        if (pass_q == PASS_W'(PASSES - 1)) begin
          found_t_d   = t_cand;
          found_p_d   = peak_q;
          out_valid_d = 1'b1;
          out_rsp_d   = '{threshold: t_cand, peak_height: peak_q,
                          below_count: cnt_q, height_out: '0};
        end else begin
          pass_d = pass_q + PASS_W'(1);
          addr_d = '0;
          cnt_d  = '0;
        end
      end
      ST_RD_WAIT: begin
        rem_d  = num[2*HGT_W-1:HGT_W];
        quo_d  = num[HGT_W-1:0];
        dvs_d  = dvs_init;
        step_d = '0;
        out_rsp_d = '0;
        if (rd_q < found_t_q) begin
          out_valid_d = 1'b1;
        end else if (!rescale_q) begin
          out_valid_d          = 1'b1;
          out_rsp_d.height_out = rd_q;
        end else if (found_p_q <= found_t_q || num_ovf) begin
          // zero divisor or quotient past full scale: saturate
          out_valid_d          = 1'b1;
          out_rsp_d.height_out = '1;
        end
      end
      ST_DIV: begin
        rem_d  = r_ge ? r_sub[HGT_W-1:0] : r_shift[HGT_W-1:0];
        quo_d  = quo_next;
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          out_valid_d = 1'b1;
          out_rsp_d   = '0;
          // hold at least one step above zero
          out_rsp_d.height_out = (quo_next == '0) ? HGT_W'(1) : quo_next;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= 1'b0;
      found_t_q   <= '0;
      found_p_q   <= '0;
      target_q    <= TARGET_RESET;
      rescale_q   <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
      found_t_q   <= found_t_d;
      found_p_q   <= found_p_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TARGET:  target_q  <= cfg_wdata_i;
          CFG_RESCALE: rescale_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    addr_q    <= addr_d;
    cnt_q     <= cnt_d;
    peak_q    <= peak_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    pass_q    <= pass_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    dvs_q     <= dvs_d;
    step_q    <= step_d;
  end

endmodule

@@ tb/sv/quantile_threshold_remap_test.sv @@
module quantile_threshold_remap_test;
  import qtr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code the block must ignore: no response, no state change.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Idle cycles let pass before a register write once everything expected has
  // arrived; a write or an ignored request can still be in the block then.
  localparam int unsigned SETTLE_CYCLES = 32;

  // Receiver hold-off: length and the response counts at which it starts.
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_FIRST  = 40;
  localparam int unsigned HOLD_STEP   = 120;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_TARGET;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  quantile_threshold_remap dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: height map, last threshold search and registers.
  // ---------------------------------------------------------------------------
  logic [HGT_W-1:0] height_map [PIXEL_COUNT];
  logic [HGT_W-1:0] thr_found   = '0;
  logic [HGT_W-1:0] peak_found  = '0;
  logic [TGT_W-1:0] target_frac = TARGET_RESET;
  logic             rescale_on  = 1'b1;

  req_t pending_q [$];   // requests not yet offered to the block
  rsp_t expect_q [$];    // predicted responses, oldest first

  int unsigned reqs_issued = 0;
  int unsigned reqs_taken  = 0;
  int unsigned rsp_seen    = 0;
  int unsigned errors      = 0;
  logic        req_taken   = 1'b0;

  // Apply one request to the shadow state; return 1 when it yields a response.
  function automatic bit apply_request(input req_t rq, output rsp_t rs);
    int unsigned hist [256];
    int unsigned lo, hi, mid, cut, below, top, h, v;
    bit          has_rsp;
    rs      = '0;
    has_rsp = 1'b0;
    case (rq.operation)
      OP_WRITE: begin
        height_map[rq.pixel_index] = rq.height_in;
      end
      OP_COMPUTE: begin
        // Build a histogram once; each bisection pass then sums the bins
        // below its candidate instead of walking the whole map.
        for (int b = 0; b < 256; b++) hist[b] = 0;
        top = 0;
        for (int p = 0; p < PIXEL_COUNT; p++) begin
          hist[height_map[p]]++;
          if (height_map[p] > top) top = height_map[p];
        end
        lo    = 0;
        hi    = 256;
        cut   = 0;
        below = 0;
        repeat (PASSES) begin
          mid   = (lo + hi) >> 1;
          cut   = (255 * mid) >> 8;
          below = 0;
          for (int b = 0; b < cut; b++) below += hist[b];
          // Raise the low bound while too few pixels sit below the candidate.
          if (longint'(target_frac) * PIXEL_COUNT > longint'(below) * 65536) lo = mid;
          else hi = mid;
        end
        thr_found      = cut[HGT_W-1:0];
        peak_found     = top[HGT_W-1:0];
        rs.threshold   = cut[HGT_W-1:0];
        rs.peak_height = top[HGT_W-1:0];
        rs.below_count = below[CNT_W-1:0];
        has_rsp        = 1'b1;
      end
      OP_READ: begin
        h = height_map[rq.pixel_index];
        if (h < thr_found) v = 0;
        else if (!rescale_on) v = h;
        else if (peak_found <= thr_found) v = 255;       // zero divisor
        else begin
          v = (255 * (h - thr_found)) / (peak_found - thr_found);
          if (v > 255) v = 255;                         // pixel above old peak
          if (v < 1) v = 1;
        end
        rs.height_out = v[HGT_W-1:0];
        has_rsp       = 1'b1;
      end
      default: ;
    endcase
    return has_rsp;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: track register writes and accepted requests, score responses.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    rsp_t got;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TARGET:  target_frac = cfg_wdata[TGT_W-1:0];
          CFG_RESCALE: rescale_on  = cfg_wdata[0];
          default: ;
        endcase
      end

      // Score the response first; the block cannot answer a request in the
      // cycle it accepts it.
      if (out_valid && out_ready) begin
        got = out_rsp;
        rsp_seen++;
        if (expect_q.size() == 0) begin
          errors++;
          $display("%0t ns: response with none expected, actual %h", $time, got);
        end else begin
          want = expect_q.pop_front();
          check_field("threshold", want.threshold, got.threshold);
          check_field("peak_height", want.peak_height, got.peak_height);
          check_field("below_count", want.below_count, got.below_count);
          check_field("height_out", want.height_out, got.height_out);
        end
      end

      if (in_valid && in_ready) begin
        reqs_taken++;
        if (apply_request(in_req, want)) expect_q.push_back(want);
      end
    end
    req_taken <= rst_n && in_valid && in_ready;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued requests in bursts separated by random gaps.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : req_driver
    // Hold valid and payload until the request is taken.
    if (!in_valid || req_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_req   <= pending_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) burst_left--;
        else begin
          // Start a new burst; about one in four runs on with no gap at all.
          burst_left = $urandom_range(0, 23);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a random 16-bit mask, redrawn once it has been stepped through, plus long hold-offs.
  // ---------------------------------------------------------------------------
  int unsigned   hold_left = 0;
  int unsigned   hold_mark = HOLD_FIRST;
  logic [15:0]   stall_mask = '1;
  logic [3:0]    stall_pos  = '0;

  always @(negedge clk) begin : rsp_receiver
    logic rdy;
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (rsp_seen >= hold_mark) begin
      // Stop draining for a long stretch so the block fills and stalls input.
      hold_left = HOLD_CYCLES - 1;
      hold_mark = hold_mark + HOLD_STEP;
      rdy       = 1'b0;
    end else begin
      if (stall_pos == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    stall_mask = '1;
          2:       stall_mask = 16'($urandom);
          default: stall_mask = 16'($urandom & $urandom);
        endcase
      end
      rdy       = stall_mask[stall_pos];
      stall_pos = stall_pos + 1'b1;
    end
    out_ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] op, input int unsigned idx,
                          input int unsigned hgt);
    req_t rq;
    rq.operation   = op;
    rq.pixel_index = idx[ADDR_W-1:0];
    rq.height_in   = hgt[HGT_W-1:0];
    pending_q.push_back(rq);
    reqs_issued++;
  endtask

  // Wait until every request is taken and every response has come, then idle.
  task automatic settle();
    do @(negedge clk); while (reqs_taken != reqs_issued || expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Slowest correct run: at most 15 compute requests and under 5000 other
  // requests, plus sender gaps, receiver stalls and the long hold-offs; the
  // watchdog below allows well beyond that.
  initial begin : watchdog
    #25_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned spare_computes;
    int unsigned last_wr;
    int unsigned roll;
    logic [CFG_W-1:0] tgt;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reads before any compute: threshold and peak are zero, so a rescaled
    // pixel comes back as full scale. Also try the unused operation code.
    push_req(OP_WRITE, 0, 255);
    push_req(OP_WRITE, 1, 0);
    push_req(OP_READ, 0, $urandom_range(0, 255));
    push_req(OP_READ, 1, $urandom_range(0, 255));
    push_req(OP_UNUSED, $urandom_range(0, PIXEL_COUNT - 1), $urandom_range(0, 255));

    // Fill the whole map before any compute; keep the peak at 251 so the
    // highest target later lands the threshold right on the peak.
    for (int p = 0; p < PIXEL_COUNT; p++)
      push_req(OP_WRITE, p, (p == PIXEL_COUNT - 1) ? 251 : $urandom_range(0, 251));
    push_req(OP_COMPUTE, $urandom_range(0, PIXEL_COUNT - 1), $urandom_range(0, 255));
    push_req(OP_READ, PIXEL_COUNT - 1, 0);
    push_req(OP_READ, 2, 0);

    // Target beyond one: every pass raises the low bound, threshold equals
    // the peak and a rescaled read hits the zero divisor.
    settle();
    set_reg(CFG_TARGET, 17'h1FFFF);
    push_req(OP_COMPUTE, 0, 0);
    push_req(OP_READ, PIXEL_COUNT - 1, 0);
    push_req(OP_READ, 3, 0);

    // Target zero: threshold drops to its lowest value, 3. Check the clamp to one at
    // the threshold and saturation for a pixel written above the peak.
    settle();
    set_reg(CFG_TARGET, 17'd0);
    push_req(OP_COMPUTE, PIXEL_COUNT - 1, 255);
    push_req(OP_WRITE, 100, 3);
    push_req(OP_READ, 100, 0);
    push_req(OP_WRITE, 101, 255);
    push_req(OP_READ, 101, 0);
    push_req(OP_WRITE, 102, 2);
    push_req(OP_READ, 102, 0);

    // Full-scale target with heights kept as they are.
    settle();
    set_reg(CFG_TARGET, 17'd65536);
    set_reg(CFG_RESCALE, CFG_W'(0));
    push_req(OP_COMPUTE, 0, 0);
    push_req(OP_READ, 101, 0);
    push_req(OP_READ, 100, 0);
    push_req(OP_READ, 7, 0);

    // Random segments, each under a fresh register setting and opened by a
    // compute so the reads that follow remap against a new threshold.
    spare_computes = 6;
    last_wr        = 0;
    for (int seg = 0; seg < 5; seg++) begin
      settle();
      case ($urandom_range(0, 4))
        0:       tgt = 17'd0;
        1:       tgt = 17'd65536;
        2:       tgt = 17'h1FFFF;
        3:       tgt = CFG_W'($urandom_range(0, 65536));
        default: tgt = CFG_W'($urandom_range(0, 17'h1FFFF));
      endcase
      set_reg(CFG_TARGET, tgt);
      set_reg(CFG_RESCALE, CFG_W'($urandom_range(0, 1)));
      push_req(OP_COMPUTE, $urandom_range(0, PIXEL_COUNT - 1), $urandom_range(0, 255));
      repeat (110) begin
        roll = $urandom_range(0, 99);
        if (roll < 2 && spare_computes != 0) begin
          spare_computes--;
          push_req(OP_COMPUTE, $urandom_range(0, PIXEL_COUNT - 1), $urandom_range(0, 255));
        end else if (roll < 5) begin
          push_req(OP_UNUSED, $urandom_range(0, PIXEL_COUNT - 1), $urandom_range(0, 255));
        end else if (roll < 45) begin
          last_wr = $urandom_range(0, PIXEL_COUNT - 1);
          push_req(OP_WRITE, last_wr, $urandom_range(0, 255));
        end else if (roll < 60) begin
          // Read back the pixel just written.
          push_req(OP_READ, last_wr, $urandom_range(0, 255));
        end else begin
          push_req(OP_READ, $urandom_range(0, PIXEL_COUNT - 1), $urandom_range(0, 255));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/qtr_pkg.sv
hw/rtl/quantile_threshold_remap.sv
tb/sv/quantile_threshold_remap_test.sv
